FILE: rtl/core/mie_pkg.sv
// Shared types and constants for the modular inverse block.
package mie_pkg;

  localparam int unsigned FIELD_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RALIGN,
    ST_RSUB,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_FINISH,
    ST_DONE
  } mie_state_t;

  // core status seen by the stream wrapper
  typedef struct packed {
    logic idle;
    logic done;
  } mie_stat_t;

endpackage

FILE: rtl/core/mie_core.sv
// Sequenced extended-Euclid engine built around one shared subtract/compare unit.
module mie_core #(
  parameter int unsigned WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                take,
  input  logic [WIDTH-1:0]    value,
  input  logic [WIDTH-1:0]    modulus,
  output logic [WIDTH-1:0]    inverse,
  output logic                exists,
  output mie_pkg::mie_stat_t  stat
);
  import mie_pkg::*;

  localparam int unsigned W1 = WIDTH + 1;
  localparam int unsigned KW = $clog2(WIDTH);

  mie_state_t state, state_next;

  logic [W1-1:0]    rem, rem_next;
  logic [W1-1:0]    dvs, dvs_next;
  logic [KW-1:0]    k, k_next;
  logic [WIDTH-1:0] m_reg, m_reg_next;
  logic [WIDTH-1:0] r_old, r_old_next;
  logic [WIDTH-1:0] r_cur, r_cur_next;
  logic [W1-1:0]    t_old, t_old_next;
  logic [W1-1:0]    t_cur, t_cur_next;
  logic [W1-1:0]    acc, acc_next;
  logic             neg_old, neg_old_next;
  logic             neg_cur, neg_cur_next;
  logic [WIDTH-1:0] res, res_next;
  logic             ok, ok_next;

  // shared unit: op_a - op_b with borrow out
  logic [W1-1:0] op_a, op_b;
  logic [W1:0]   diff;
  logic          ge;
  logic [W1-1:0] rem_sub;
  logic [W1-1:0] acc_sum;
  logic          mod_small;

  assign diff      = {1'b0, op_a} - {1'b0, op_b};
  assign ge        = ~diff[W1];
  assign rem_sub   = ge ? diff[W1-1:0] : rem;
  assign acc_sum   = {acc[W1-2:0], 1'b0} + (ge ? t_cur : '0);
  assign mod_small = (modulus[WIDTH-1:1] == '0);

  always_comb begin
    case (state)
      ST_RALIGN, ST_ALIGN: begin
        op_a = rem;
        op_b = {dvs[W1-2:0], 1'b0};
      end
      ST_FINISH: begin
        op_a = {1'b0, m_reg};
        op_b = t_old;
      end
      default: begin
        op_a = rem;
        op_b = dvs;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = mod_small ? ST_DONE : ST_RALIGN;
      ST_RALIGN: if (!ge) state_next = ST_RSUB;
      ST_RSUB:   if (k == '0) state_next = ST_CHECK;
      ST_CHECK:  state_next = (r_cur == '0) ? ST_FINISH : ST_ALIGN;
      ST_ALIGN:  if (!ge) state_next = ST_SUB;
      ST_SUB:    if (k == '0) state_next = ST_CHECK;
      ST_FINISH: state_next = ST_DONE;
      ST_DONE:   if (take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    rem_next     = rem;
    dvs_next     = dvs;
    k_next       = k;
    m_reg_next   = m_reg;
    r_old_next   = r_old;
    r_cur_next   = r_cur;
    t_old_next   = t_old;
    t_cur_next   = t_cur;
    acc_next     = acc;
    neg_old_next = neg_old;
    neg_cur_next = neg_cur;
    res_next     = res;
    ok_next      = ok;
    case (state)
      ST_IDLE: begin
        if (start) begin
          m_reg_next = modulus;
          rem_next   = {1'b0, value};
          dvs_next   = {1'b0, modulus};
          k_next     = '0;
          res_next   = '0;
          ok_next    = 1'b0;
        end
      end
      ST_RALIGN, ST_ALIGN: begin
        if (ge) begin
          dvs_next = {dvs[W1-2:0], 1'b0};
          k_next   = k + KW'(1);
        end
      end
      ST_RSUB: begin
        rem_next = rem_sub;
        if (k == '0) begin
          // value mod modulus is ready: seed the chain
          r_old_next   = m_reg;
          r_cur_next   = rem_sub[WIDTH-1:0];
          t_old_next   = '0;
          t_cur_next   = W1'(1);
          neg_old_next = 1'b0;
          neg_cur_next = 1'b0;
        end else begin
          dvs_next = {1'b0, dvs[W1-1:1]};
          k_next   = k - KW'(1);
        end
      end
      ST_SUB: begin
        rem_next = rem_sub;
        acc_next = acc_sum;
        if (k == '0) begin
          r_old_next   = r_cur;
          r_cur_next   = rem_sub[WIDTH-1:0];
          t_old_next   = t_cur;
          t_cur_next   = t_old + acc_sum;
          neg_old_next = neg_cur;
          neg_cur_next = ~neg_cur;
        end else begin
          dvs_next = {1'b0, dvs[W1-1:1]};
          k_next   = k - KW'(1);
        end
      end
      ST_CHECK: begin
        if (r_cur != '0) begin
          rem_next = {1'b0, r_old};
          dvs_next = {1'b0, r_cur};
          acc_next = '0;
          k_next   = '0;
        end
      end
      ST_FINISH: begin
        if (r_old == WIDTH'(1)) begin
          ok_next = 1'b1;
          if (t_old == {1'b0, m_reg}) begin
            res_next = '0;
          end else if (neg_old && (t_old != '0)) begin
            res_next = diff[WIDTH-1:0];
          end else begin
            res_next = t_old[WIDTH-1:0];
          end
        end else begin
          ok_next  = 1'b0;
          res_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    rem     <= rem_next;
    dvs     <= dvs_next;
    k       <= k_next;
    m_reg   <= m_reg_next;
    r_old   <= r_old_next;
    r_cur   <= r_cur_next;
    t_old   <= t_old_next;
    t_cur   <= t_cur_next;
    acc     <= acc_next;
    neg_old <= neg_old_next;
    neg_cur <= neg_cur_next;
    res     <= res_next;
    ok      <= ok_next;
  end

  assign inverse   = res;
  assign exists    = ok;
  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

endmodule

FILE: rtl/core/modular_inverse_euclid.sv
// Top level: stream wrapper around the modular inverse engine.
// Sequence: reduce value modulo modulus, then run Euclid steps until the remainder is zero;
//   a modulus below 2 skips both and reports no inverse.
// Throughput: one item in flight; the next beat is taken once the result leaves the engine.
// Reset: rst is synchronous, active high; clears the sequencer and the output valid.
module modular_inverse_euclid #(
  parameter int unsigned WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] value, [31:16] modulus
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] inverse
  output logic        m_tuser    // [0] exists
);
  import mie_pkg::*;

  logic [WIDTH-1:0] value_w;
  logic [WIDTH-1:0] modulus_w;
  logic [WIDTH-1:0] core_inverse;
  logic             core_exists;
  mie_stat_t        core_stat;
  logic             start;
  logic             take;

  // fields are used in their low WIDTH bits, zero-extended when WIDTH is wider
  assign value_w   = WIDTH'(s_tdata[FIELD_W-1:0]);
  assign modulus_w = WIDTH'(s_tdata[2*FIELD_W-1:FIELD_W]);

  // engine takes a beat only when idle
  assign s_tready = core_stat.idle;
  assign start    = s_tvalid & s_tready;

  // result moves to the output register when that register is free or draining
  assign take = core_stat.done & (~m_tvalid | m_tready);

  mie_core #(
    .WIDTH(WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .take    (take),
    .value   (value_w),
    .modulus (modulus_w),
    .inverse (core_inverse),
    .exists  (core_exists),
    .stat    (core_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (take) begin
      m_tdata <= FIELD_W'(core_inverse);
      m_tuser <= core_exists;
    end
  end

endmodule

FILE: bench/modular_inverse_euclid_test.sv
// Self-checking stream testbench for the modular inverse engine.
`timescale 1ns / 1ps

module modular_inverse_euclid_test;

  localparam int unsigned W         = mie_pkg::FIELD_W;
  localparam int unsigned LONG_HOLD = 400;       // receiver hold-off, in cycles
  localparam int unsigned BATCH_A   = 300;
  localparam int unsigned BATCH_B   = 600;
  localparam int unsigned TAIL      = 200;       // quiet cycles after the last result
  localparam time         RUN_LIMIT = 4_000_000; // ns, well past the slowest legal run

  // One expected result, tagged with the operands that produced it.
  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic [W-1:0] inverse;
    logic         exists;
  } inverse_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [15:0] value, [31:16] modulus
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [15:0] inverse
  logic        m_tuser;         // [0] exists

  logic [31:0]     operand_queue[$];   // beats still to be offered
  inverse_result_t inverse_queue[$];   // results owed by the engine
  logic            in_beat = 1'b0;     // input beat taken at the last rising edge

  int unsigned queued_total = 0;
  int unsigned beats_in     = 0;
  int unsigned with_inverse = 0;
  int unsigned no_inverse   = 0;
  int unsigned fail_count   = 0;
  int unsigned hold_req     = 0;       // bumped by the sequence to ask for a long hold
  int unsigned hold_seen    = 0;

  // sender / receiver pacing state, each owned by its own process
  int unsigned send_gap   = 0;
  int unsigned send_calm  = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned recv_calm  = 0;

  modular_inverse_euclid #(.WIDTH(W)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Extended Euclid with the coefficient held as magnitude plus sign.
  // Signs alternate each step and magnitudes stay within the modulus.
  function automatic inverse_result_t inverse_predict(input logic [W-1:0] a,
                                                      input logic [W-1:0] m);
    longint unsigned r_prev, r_cur, r_next, t_prev, t_cur, t_next, quot;
    bit              neg_prev, neg_cur, neg_next;
    inverse_result_t res;
    res         = '0;
    res.value   = a;
    res.modulus = m;
    if (m < 2) return res;              // modulus 0 or 1: no inverse
    r_prev   = m;
    r_cur    = a % m;                   // value reduced first
    t_prev   = 0;
    neg_prev = 1'b0;
    t_cur    = 1;
    neg_cur  = 1'b0;
    while (r_cur != 0) begin
      quot     = r_prev / r_cur;
      r_next   = r_prev % r_cur;
      t_next   = t_prev + quot * t_cur;
      neg_next = !neg_cur;
      r_prev   = r_cur;
      r_cur    = r_next;
      t_prev   = t_cur;
      neg_prev = neg_cur;
      t_cur    = t_next;
      neg_cur  = neg_next;
    end
    if (r_prev != 1) return res;        // gcd above 1
    res.exists = 1'b1;
    t_prev     = t_prev % m;
    res.inverse = (neg_prev && t_prev != 0) ? W'(m - t_prev) : W'(t_prev);
    return res;
  endfunction

  // Idle length: mostly none or short, a few long.
  function automatic int unsigned draw_idle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random operand pair, packed as {modulus, value}.
  function automatic logic [31:0] random_operands();
    int unsigned pick, v, m, k, g, f_lo, f_hi, f_tmp, steps;
    logic [W-1:0] corner[5];
    corner = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF};
    pick = $urandom_range(0, 99);
    v = $urandom_range(0, 65535);
    m = $urandom_range(2, 65535);
    if (pick < 35) begin
      // fully random operands
    end else if (pick < 50) begin
      m = $urandom_range(2, 64);                        // deep reduction
    end else if (pick < 58) begin
      m = $urandom_range(32768, 65535) | 1;             // large odd modulus
    end else if (pick < 64) begin
      k = $urandom_range(0, (65535 - 1) / m);           // value congruent to 1
      v = k * m + 1;
    end else if (pick < 68) begin
      k = $urandom_range(0, 65535 / m);                 // value congruent to 0
      v = k * m;
    end else if (pick < 78) begin
      g = $urandom_range(2, 255);                       // shared factor
      v = g * $urandom_range(0, 65535 / g);
      m = g * $urandom_range(1, 65535 / g);
    end else if (pick < 90) begin
      // neighboring Fibonacci numbers give the longest division chains
      f_lo  = 1;
      f_hi  = 2;
      steps = $urandom_range(2, 21);
      repeat (steps) begin
        f_tmp = f_lo + f_hi;
        f_lo  = f_hi;
        f_hi  = f_tmp;
      end
      v = f_lo;
      m = f_hi;
      if ($urandom_range(0, 1)) begin
        v = f_hi;
        m = f_lo < 2 ? 2 : f_lo;
      end
    end else if (pick < 94) begin
      m = $urandom_range(0, 1);                         // degenerate modulus
    end else begin
      v = corner[$urandom_range(0, 4)];
      m = corner[$urandom_range(0, 4)];
    end
    return {W'(m), W'(v)};
  endfunction

  task automatic queue_operands(input logic [W-1:0] value, input logic [W-1:0] modulus);
    operand_queue.push_back({modulus, value});
    queued_total++;
  endtask

  // Returns once every queued beat is in and every result is back.
  task automatic wait_drained();
    while (beats_in != queued_total || inverse_queue.size() != 0) @(negedge clk);
  endtask

  // Sender: holds a beat until taken, then idles or offers the next one.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_beat) begin
      // beat still waiting for the engine
    end else if (send_gap > 0) begin
      send_gap--;
      s_tvalid <= 1'b0;
    end else if (operand_queue.size() != 0) begin
      s_tdata  <= operand_queue.pop_front();
      s_tvalid <= 1'b1;
      if (send_calm > 0) begin
        send_calm--;
        send_gap = 0;
      end else begin
        send_gap = draw_idle();
        if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(15, 40);
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls, calm stretches, and a long hold on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 5) == 0) stall_left = draw_idle();
      else if ($urandom_range(0, 60) == 0) recv_calm = $urandom_range(30, 100);
    end
  end

  // Input beats create expectations; output beats are checked in order.
  always @(posedge clk) begin
    inverse_result_t want;
    if (rst) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        inverse_queue.push_back(inverse_predict(s_tdata[W-1:0], s_tdata[2*W-1:W]));
        beats_in++;
      end
      if (m_tvalid && m_tready) begin
        if (inverse_queue.size() == 0) begin
          $error("unexpected result beat: inverse %0d exists %0d", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = inverse_queue.pop_front();
          if (want.exists) with_inverse++;
          else no_inverse++;
          if (m_tdata !== want.inverse) begin
            $error("inverse mismatch (value %0d, modulus %0d): expected %0d, actual %0d",
                   want.value, want.modulus, want.inverse, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.exists) begin
            $error("exists mismatch (value %0d, modulus %0d): expected %0d, actual %0d",
                   want.value, want.modulus, want.exists, m_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    queue_operands(16'd0,     16'd7);      // zero value
    queue_operands(16'd1,     16'd7);      // value one
    queue_operands(16'd8,     16'd7);      // congruent to one
    queue_operands(16'd14,    16'd7);      // congruent to zero
    queue_operands(16'd3,     16'd0);      // modulus zero
    queue_operands(16'd3,     16'd1);      // modulus one
    queue_operands(16'd0,     16'd0);
    queue_operands(16'hFFFF,  16'hFFFF);
    queue_operands(16'hFFFE,  16'hFFFF);   // minus one is its own inverse
    queue_operands(16'hFFFF,  16'd2);
    queue_operands(16'd2,     16'hFFFF);
    queue_operands(16'd6,     16'd9);      // common factor
    queue_operands(16'hFFFF,  16'hFFFE);   // value above modulus, congruent to one
    queue_operands(16'd1,     16'd2);
    queue_operands(16'd0,     16'd2);
    queue_operands(16'd12345, 16'd65521);
    queue_operands(16'd28657, 16'd46368);  // Fibonacci neighbors, longest chain
    queue_operands(16'd46368, 16'd28657);
    queue_operands(16'h8000,  16'hFFFF);
    queue_operands(16'h5555,  16'hAAAA);
    queue_operands(16'hAAAA,  16'h5555);
    queue_operands(16'd3,     16'h8000);
    queue_operands(16'd65521, 16'hFFFF);
    wait_drained();                       // sender pauses until all results are back

    @(posedge clk);
    repeat (BATCH_A) begin
      logic [31:0] pair;
      pair = random_operands();
      queue_operands(pair[W-1:0], pair[2*W-1:W]);
    end
    wait_drained();

    // second batch: long receiver hold while the sender keeps offering
    @(posedge clk);
    repeat (BATCH_B) begin
      logic [31:0] pair;
      pair = random_operands();
      queue_operands(pair[W-1:0], pair[2*W-1:W]);
    end
    while (beats_in + BATCH_B - 100 < queued_total) @(negedge clk);
    @(posedge clk);
    hold_req <= hold_req + 1;
    wait_drained();

    repeat (TAIL) @(posedge clk);
    $display("summary: %0d beats checked, %0d with an inverse, %0d without",
             beats_in, with_inverse, no_inverse);
    $display("summary: directed corners, random batches, %0d long output hold(s)", hold_req);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("tb: failure");
    $finish;
  end

endmodule
